>>> hw/rtl/decimal_seven_segment_encoder_defines.svh
// Assertion macros shared by the encoder RTL.
`ifndef DECIMAL_SEVEN_SEGMENT_ENCODER_DEFINES_SVH
`define DECIMAL_SEVEN_SEGMENT_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DSSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/dsse_pkg.sv
package dsse_pkg;

   // Field widths of the item and result channels.
   localparam int VALUE_WIDTH   = 27;
   localparam int DIGIT_WIDTH   = 4;
   localparam int INDEX_WIDTH   = 3;
   localparam int SEGMENT_WIDTH = 8;
   localparam int PATTERN_WIDTH = 7;
   localparam int COUNT_WIDTH   = 4;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COMMON_CATHODE = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIGIT_COUNT    = CSR_INDEX_WIDTH'(1);

   localparam logic [COUNT_WIDTH-1:0] DIGIT_COUNT_RESET = COUNT_WIDTH'(4);

   // Default number of digit cells in the chain.
   localparam int DEFAULT_MAX_DIGITS = 8;

   // Bit counter for the serial conversion.
   localparam int BIT_COUNT_WIDTH = $clog2(VALUE_WIDTH);

   // Operation applied to all cells of the digit chain together.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_DABBLE,
      CELL_SHIFT
   } dsse_cell_op_type;

   // Segments a..g in bits 0..6 for a lit decimal digit.
   function automatic logic [PATTERN_WIDTH-1:0] digit_pattern(
      input logic [DIGIT_WIDTH-1:0] digit
   );
      logic [PATTERN_WIDTH-1:0] pattern;
      unique case (digit)
         4'd0:    pattern = 7'b0111111;
         4'd1:    pattern = 7'b0000110;
         4'd2:    pattern = 7'b1011011;
         4'd3:    pattern = 7'b1001111;
         4'd4:    pattern = 7'b1100110;
         4'd5:    pattern = 7'b1101101;
         4'd6:    pattern = 7'b1111101;
         4'd7:    pattern = 7'b0000111;
         4'd8:    pattern = 7'b1111111;
         4'd9:    pattern = 7'b1100111;
         default: pattern = 7'b0000000;
      endcase
      return pattern;
   endfunction

endpackage

>>> hw/rtl/dsse_digit_cell.sv
module dsse_digit_cell (
   input  logic                                 clock,
   input  dsse_pkg::dsse_cell_op_type           cell_op,
   input  logic                                 bit_in,
   input  logic [dsse_pkg::DIGIT_WIDTH-1:0]     upper_digit,
   output logic [dsse_pkg::DIGIT_WIDTH-1:0]     digit,
   output logic                                 carry_out
);
   import dsse_pkg::*;

   logic [DIGIT_WIDTH-1:0] digit_ff;
   logic [DIGIT_WIDTH-1:0] digit_in;
   logic [DIGIT_WIDTH-1:0] adjusted;

   // Add three to digits of five and above so the doubling carries in decimal.
   assign adjusted  = (digit_ff >= DIGIT_WIDTH'(5)) ? digit_ff + DIGIT_WIDTH'(3) : digit_ff;
   assign carry_out = adjusted[DIGIT_WIDTH-1];

   // Next digit for the operation the controller asks of the whole chain.
   always_comb begin
      unique case (cell_op)
         CELL_HOLD:   digit_in = digit_ff;
         CELL_CLEAR:  digit_in = '0;
         CELL_DABBLE: digit_in = {adjusted[DIGIT_WIDTH-2:0], bit_in};
         CELL_SHIFT:  digit_in = upper_digit;
         default:     digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

>>> hw/rtl/decimal_seven_segment_encoder.sv
// Converts an unsigned 27-bit value to decimal and emits one seven-segment result per
// attached digit, least significant first, with the final one flagged by last_digit.
// Digits beyond MAX_DIGITS are dropped, so the value is shown modulo 10^MAX_DIGITS, and
// leading zeros are shown as zeros. An item is taken while idle, then shifted bit by bit
// through a chain of decimal digit cells, then the chain shifts one digit per cycle
// towards the output register while the result side does not stall. No new item is
// taken before the last digit of the clamped count is out. With a digit count of zero
// no result is produced and the next item can be taken in the following cycle. The
// configuration registers are written through the csr_ port: index 0 selects common
// cathode drive (lit segments high), index 1 sets the digit count; other indexes are
// ignored. The decimal point in bit 7 is never lit.
`include "decimal_seven_segment_encoder_defines.svh"

module decimal_seven_segment_encoder #(
   parameter int MAX_DIGITS = dsse_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [dsse_pkg::VALUE_WIDTH-1:0]        req_value,

   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [dsse_pkg::INDEX_WIDTH-1:0]        rsp_digit_index,
   output logic [dsse_pkg::DIGIT_WIDTH-1:0]        rsp_decimal_digit,
   output logic [dsse_pkg::SEGMENT_WIDTH-1:0]      rsp_segment_levels,
   output logic                                    rsp_last_digit,

   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [dsse_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [dsse_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);
   import dsse_pkg::*;

   localparam logic [COUNT_WIDTH-1:0]     MAX_COUNT = COUNT_WIDTH'(MAX_DIGITS);
   localparam logic [BIT_COUNT_WIDTH-1:0] LAST_BIT  = BIT_COUNT_WIDTH'(VALUE_WIDTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   // Registers and their next values.
   state_type                   state_ff,          state_in;
   logic                        common_cathode_ff, common_cathode_in;
   logic [COUNT_WIDTH-1:0]      digit_count_ff,    digit_count_in;
   logic [VALUE_WIDTH-1:0]      binary_ff,         binary_in;
   logic [BIT_COUNT_WIDTH-1:0]  bit_count_ff,      bit_count_in;
   logic [COUNT_WIDTH-1:0]      emit_count_ff,     emit_count_in;
   logic [INDEX_WIDTH-1:0]      index_ff,          index_in;
   logic                        rsp_valid_ff,      rsp_valid_in;
   logic [INDEX_WIDTH-1:0]      rsp_index_ff,      rsp_index_in;
   logic [DIGIT_WIDTH-1:0]      rsp_digit_ff,      rsp_digit_in;
   logic [SEGMENT_WIDTH-1:0]    rsp_levels_ff,     rsp_levels_in;
   logic                        rsp_last_ff,       rsp_last_in;

   logic                        req_accept;
   logic                        load_result;
   logic                        last_emit;
   logic [COUNT_WIDTH-1:0]      clamped_count;
   logic [PATTERN_WIDTH-1:0]    pattern;
   dsse_cell_op_type            cell_op;

   logic [DIGIT_WIDTH-1:0]      cell_digit [MAX_DIGITS];
   logic [MAX_DIGITS-1:0]       cell_carry;

   // Chain of decimal digit cells; cell 0 holds the least significant digit.
   // The carry out of the top cell is the dropped overflow bit.
   for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
      logic                   bit_in;
      logic [DIGIT_WIDTH-1:0] upper_digit;

      if (g == 0) begin : g_first
         assign bit_in = binary_ff[VALUE_WIDTH-1];
      end else begin : g_next
         assign bit_in = cell_carry[g-1];
      end

      if (g == MAX_DIGITS - 1) begin : g_top
         assign upper_digit = '0;
      end else begin : g_inner
         assign upper_digit = cell_digit[g+1];
      end

      dsse_digit_cell u_cell (
         .clock       (clock),
         .cell_op     (cell_op),
         .bit_in      (bit_in),
         .upper_digit (upper_digit),
         .digit       (cell_digit[g]),
         .carry_out   (cell_carry[g])
      );
   end

   // Handshake decisions.
   assign req_stall     = (state_ff != ST_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign csr_ready     = 1'b1;
   assign load_result   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign last_emit     = ((COUNT_WIDTH'(index_ff) + COUNT_WIDTH'(1)) == emit_count_ff);
   assign clamped_count = (digit_count_ff > MAX_COUNT) ? MAX_COUNT : digit_count_ff;
   assign pattern       = digit_pattern(cell_digit[0]);

   // Next state of the controller, the registers and the output stage.
   always_comb begin
      state_in          = state_ff;
      common_cathode_in = common_cathode_ff;
      digit_count_in    = digit_count_ff;
      binary_in         = binary_ff;
      bit_count_in      = bit_count_ff;
      emit_count_in     = emit_count_ff;
      index_in          = index_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_index_in      = rsp_index_ff;
      rsp_digit_in      = rsp_digit_ff;
      rsp_levels_in     = rsp_levels_ff;
      rsp_last_in       = rsp_last_ff;
      cell_op           = CELL_HOLD;

      // Register writes; unknown indexes are ignored.
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COMMON_CATHODE: common_cathode_in = csr_data[0];
            CSR_DIGIT_COUNT:    digit_count_in    = csr_data;
            default:            ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cell_op       = CELL_CLEAR;
               binary_in     = req_value;
               bit_count_in  = '0;
               index_in      = '0;
               emit_count_in = clamped_count;
               if (clamped_count != '0) begin
                  state_in = ST_CONVERT;
               end
            end
         end
         ST_CONVERT: begin
            cell_op      = CELL_DABBLE;
            binary_in    = {binary_ff[VALUE_WIDTH-2:0], 1'b0};
            bit_count_in = bit_count_ff + BIT_COUNT_WIDTH'(1);
            if (bit_count_ff == LAST_BIT) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_result) begin
               cell_op       = CELL_SHIFT;
               rsp_valid_in  = 1'b1;
               rsp_index_in  = index_ff;
               rsp_digit_in  = cell_digit[0];
               rsp_levels_in = common_cathode_ff ? {1'b0, pattern} : ~{1'b0, pattern};
               rsp_last_in   = last_emit;
               index_in      = index_ff + INDEX_WIDTH'(1);
               if (last_emit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Controller state, registers and output stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         common_cathode_ff <= 1'b0;
         digit_count_ff    <= DIGIT_COUNT_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         common_cathode_ff <= common_cathode_in;
         digit_count_ff    <= digit_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      binary_ff     <= binary_in;
      bit_count_ff  <= bit_count_in;
      emit_count_ff <= emit_count_in;
      index_ff      <= index_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_digit_ff  <= rsp_digit_in;
      rsp_levels_ff <= rsp_levels_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_digit_index    = rsp_index_ff;
   assign rsp_decimal_digit  = rsp_digit_ff;
   assign rsp_segment_levels = rsp_levels_ff;
   assign rsp_last_digit     = rsp_last_ff;

   // A pending result always holds a proper decimal digit.
   `DSSE_ASSERT_NOW(a_digit_decimal, clock, reset, rsp_valid_ff, rsp_digit_ff <= DIGIT_WIDTH'(9), "result digit above nine")
   // Once a non-final digit is taken, the chain is still emitting.
   `DSSE_ASSERT_NOW(a_more_digits, clock, reset, rsp_valid_ff && !rsp_stall && !rsp_last_ff, state_ff == ST_EMIT, "digits missing after a non-final result")
   // An item with digits to show keeps the input side stalled in the next cycle.
   `DSSE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept && (clamped_count != '0), req_stall, "input not stalled during conversion")

endmodule
